// ===== design/bhgf_pkg.sv =====
// Package for the band hysteresis glitch filter.
// Holds the mode codes, register widths, reset values and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package bhgf_pkg;

  // Default and allowed range of the sample width
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned SAMPLE_BITS_MIN = 8;
  localparam int unsigned SAMPLE_BITS_MAX = 32;

  // Configuration registers
  localparam int unsigned HW_W      = 15;  // band_half_width
  localparam int unsigned CNT_W     = 8;   // confirm_count / settle counter
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = HW_W;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HALF_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CONFIRM    = 1'd1;

  localparam logic [HW_W-1:0]  HALF_WIDTH_RST = 15'd16;
  localparam logic [CNT_W-1:0] CONFIRM_RST    = 8'd4;

  // Mode codes, also the level_state output encoding
  localparam int unsigned MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_A = 2'd0;
  localparam logic [MODE_W-1:0] MODE_T = 2'd1;
  localparam logic [MODE_W-1:0] MODE_B = 2'd2;

endpackage

// ===== design/bhgf_if.sv =====
// Stream interfaces of the band hysteresis glitch filter: sample and result.
// Each carries valid/ready and the beat payload. Depends on bhgf_pkg.
`timescale 1ns / 1ps

interface bhgf_sample_if #(
  parameter int unsigned SAMPLE_BITS = bhgf_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface bhgf_result_if ();
  logic                          valid;
  logic                          ready;
  logic                          valid_res;
  logic [bhgf_pkg::MODE_W-1:0]   level_state;

  modport source (output valid, output valid_res, output level_state, input ready);
  modport sink   (input valid, input valid_res, input level_state, output ready);
endinterface

// ===== design/band_hysteresis_glitch_filter.sv =====
// Band hysteresis glitch filter, top level.
// Uses bhgf_pkg and the stream interfaces in bhgf_if.sv.
`timescale 1ns / 1ps

// Usage
// -----
// in_bus  : sample beats (signed, SAMPLE_BITS wide), valid/ready.
// out_bus : one result beat per sample: valid_res (1 = settled on level A
//           or B) and level_state (0 level A, 1 transition, 2 level B).
// cfg_*   : write-only register port. Index 0 band_half_width, index 1
//           confirm_count; a write lands at the clock edge with cfg_we high.
//           Write only while no sample is in flight.
// Pipeline: an accepted sample goes through one input register and then
//           one result register before its result beat is valid.
// Rate    : one sample per cycle unless stalled. The state update is a pair
//           of signed band compares plus an edge add and a counter
//           increment, all done between the input and result registers.
// Stall   : when out_bus.ready is low the result register holds; the input
//           register still takes one more beat if it is empty, then
//           in_bus.ready drops until the result drains.
// Reset   : rst_n low (synchronous) clears both pipeline stages, returns
//           the registers to their defaults (16, 4), sets level A and arms
//           the first-sample seed. Band edges need no reset.
module band_hysteresis_glitch_filter #(
  parameter int unsigned SAMPLE_BITS = bhgf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  bhgf_sample_if.sink                       in_bus,
  bhgf_result_if.source                     out_bus,
  input  logic                              cfg_we,
  input  logic [bhgf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bhgf_pkg::CFG_DAT_W-1:0]    cfg_wdata
);
  import bhgf_pkg::*;

  // Band edges: sample +/- half width never wraps at this width
  localparam int unsigned EDGE_W =
    ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 1;

  // ---------------- configuration registers ----------------
  logic [HW_W-1:0]  half_width_r;
  logic [CNT_W-1:0] confirm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_width_r <= HALF_WIDTH_RST;
      confirm_r    <= CONFIRM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_HALF_WIDTH: half_width_r <= cfg_wdata[HW_W-1:0];
        CFG_IDX_CONFIRM:    confirm_r    <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline handshake ----------------
  logic                          s1_v_r;
  logic signed [SAMPLE_BITS-1:0] s1_sample_r;
  logic                          out_v_r;
  logic                          out_valid_res_r;
  logic [MODE_W-1:0]             out_state_r;

  logic out_free;   // result register can take a beat
  logic step;       // stage 1 sample is processed this cycle
  logic in_take;

  assign out_free     = !out_v_r || out_bus.ready;
  assign step         = s1_v_r && out_free;
  assign in_bus.ready = !s1_v_r || out_free;
  assign in_take      = in_bus.valid && in_bus.ready;

  // ---------------- filter state ----------------
  logic [MODE_W-1:0]        mode_r, mode_nxt;
  logic [MODE_W-1:0]        prev_r, prev_nxt;
  logic                     first_r, first_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic signed [EDGE_W-1:0] a_up_r, a_lo_r, b_up_r, b_lo_r;

  logic signed [EDGE_W-1:0] s_ext, hw_ext, seed_up, seed_lo;
  logic                     in_a, in_b;
  logic [CNT_W-1:0]         cnt_inc;
  logic                     cnt_hit;
  logic                     seed_a, seed_b;

  assign s_ext   = {{(EDGE_W-SAMPLE_BITS){s1_sample_r[SAMPLE_BITS-1]}}, s1_sample_r};
  assign hw_ext  = {{(EDGE_W-HW_W){1'b0}}, half_width_r};
  assign seed_up = s_ext + hw_ext;
  assign seed_lo = s_ext - hw_ext;

  // strict bands: a sample on an edge is outside
  assign in_a = (s_ext < a_up_r) && (s_ext > a_lo_r);
  assign in_b = (s_ext < b_up_r) && (s_ext > b_lo_r);

  assign cnt_inc = cnt_r + 1'b1;      // wraps, so a confirm of 0 means 256
  assign cnt_hit = (cnt_inc == confirm_r);

  always_comb begin
    mode_nxt  = mode_r;
    prev_nxt  = prev_r;
    first_nxt = first_r;
    cnt_nxt   = cnt_r;
    seed_a    = 1'b0;
    seed_b    = 1'b0;
    unique case (mode_r)
      MODE_A: begin
        if (first_r || in_a) begin
          seed_a    = 1'b1;
          first_nxt = 1'b0;
        end else begin
          seed_b   = 1'b1;
          cnt_nxt  = '0;
          prev_nxt = MODE_A;
          mode_nxt = MODE_T;
        end
      end
      MODE_B: begin
        if (in_b) begin
          seed_b = 1'b1;
        end else begin
          seed_a   = 1'b1;
          cnt_nxt  = '0;
          prev_nxt = MODE_B;
          mode_nxt = MODE_T;
        end
      end
      MODE_T: begin
        if (prev_r == MODE_A) begin
          // candidate B wins when both bands hold the sample
          if (in_b) begin
            seed_b  = 1'b1;
            cnt_nxt = cnt_inc;
            if (cnt_hit) begin
              prev_nxt = MODE_T;
              mode_nxt = MODE_B;
            end
          end else if (in_a) begin
            mode_nxt = MODE_A;
            prev_nxt = MODE_T;
          end
        end else begin
          if (in_a) begin
            seed_a  = 1'b1;
            cnt_nxt = cnt_inc;
            if (cnt_hit) begin
              prev_nxt = MODE_T;
              mode_nxt = MODE_A;
            end
          end else if (in_b) begin
            mode_nxt = prev_r;
            prev_nxt = MODE_T;
          end
        end
      end
      default: begin
        mode_nxt = MODE_A;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      mode_r  <= MODE_A;
      prev_r  <= MODE_A;
      first_r <= 1'b1;
      cnt_r   <= '0;
    end else begin
      if (in_bus.ready) begin
        s1_v_r <= in_bus.valid;
      end
      if (out_free) begin
        out_v_r <= s1_v_r;
      end
      if (step) begin
        mode_r  <= mode_nxt;
        prev_r  <= prev_nxt;
        first_r <= first_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  // payload registers and band edges
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_sample_r <= in_bus.sample;
    end
    if (step) begin
      out_valid_res_r <= (mode_nxt != MODE_T);
      out_state_r     <= mode_nxt;
    end
    if (step && seed_a) begin
      a_up_r <= seed_up;
      a_lo_r <= seed_lo;
    end
    if (step && seed_b) begin
      b_up_r <= seed_up;
      b_lo_r <= seed_lo;
    end
  end

  assign out_bus.valid       = out_v_r;
  assign out_bus.valid_res   = out_valid_res_r;
  assign out_bus.level_state = out_state_r;

  // ---------------- assertions ----------------
  // in transition the mode to fall back to is always a settled level
  a_prev_settled: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_T) |-> (prev_r == MODE_A || prev_r == MODE_B))
    else $error("transition without a settled previous level");

  // once a result exists, the first-sample seed has been consumed
  a_first_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !first_r)
    else $error("result issued while first sample still pending");

  // result flag agrees with its state code
  a_res_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_valid_res_r == (out_state_r != MODE_T)))
    else $error("valid_res disagrees with level_state");

  // filter state moves only when a sample is processed
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> ($stable(mode_r) && $stable(cnt_r)))
    else $error("filter state changed without a sample");

endmodule
